FILE: hw/rtl/rgb_to_hsl_converter_defines.svh
// assertion macros shared by the rgb to hsl converter rtl
`ifndef RGB_TO_HSL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_DEFINES_SVH

// antecedent implies consequent in the same cycle, off while in reset
`define RGBHSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// expression holds at every rising clock edge, off while in reset
`define RGBHSL_ASSERT_HOLD(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

`endif

FILE: hw/rtl/rgbhsl_pkg.sv
// shared types and constants of the rgb to hsl converter
`timescale 1ns / 1ps

package rgbhsl_pkg;

	// field widths
	localparam int CH_W   = 8;
	localparam int HUE_W  = 15;
	localparam int FRAC_W = 16;

	// hue scale in 1/64 degree
	localparam int unsigned HUE_SIXTH = 3840;
	localparam int unsigned HUE_FULL  = 6 * HUE_SIXTH;

	// divider geometry: quotient up to 2^16 needs 17 bits, divisors up to 510
	localparam int DIV_QW    = 17;
	localparam int DIV_DW    = 9;
	localparam int DIV_NW    = DIV_DW + DIV_QW;
	localparam int DIV_LANES = 2;

	// divider lanes
	localparam int LANE_HUE = 0;
	localparam int LANE_SAT = 1;

	// pipeline depth from first stage valid to result strobe
	localparam int PIPE_DEPTH = DIV_QW + 4;

	// hue sector, red wins ties over green, green over blue
	typedef enum logic [1:0] {
		BR_RED,
		BR_GREEN,
		BR_BLUE
	} branch_t;

	// control and lightness that travel along the divider
	typedef struct packed {
		logic              valid;
		logic              gray;
		logic [FRAC_W-1:0] lit;
	} div_ctl_t;

endpackage

FILE: hw/rtl/rgbhsl_divider.sv
// pipelined restoring divider, one quotient bit per stage, several lanes in lockstep
`timescale 1ns / 1ps

module rgbhsl_divider
	import rgbhsl_pkg::*;
#(
	parameter int LANES = DIV_LANES,
	parameter int DW    = DIV_DW,
	parameter int QW    = DIV_QW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  div_ctl_t                       in_ctl,
	input  logic [LANES-1:0][DW+QW-1:0]    num,
	input  logic [LANES-1:0][DW-1:0]       den,
	output div_ctl_t                       out_ctl,
	output logic [LANES-1:0][QW-1:0]       quo
);

	// stage registers; lo holds the remaining dividend bits on top, quotient bits below
	div_ctl_t                  ctl_s [QW];
	logic [LANES-1:0][DW-1:0]  rem_s [QW];
	logic [LANES-1:0][DW-1:0]  den_s [QW];
	logic [LANES-1:0][QW-1:0]  lo_s  [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		div_ctl_t                  ctl_prev;
		logic [LANES-1:0][DW-1:0]  rem_prev;
		logic [LANES-1:0][DW-1:0]  den_prev;
		logic [LANES-1:0][QW-1:0]  lo_prev;
		logic [LANES-1:0][DW-1:0]  rem_next;
		logic [LANES-1:0][QW-1:0]  lo_next;

		// stage input: the request itself or the previous stage
		if (j == 0) begin : g_first
			assign ctl_prev = in_ctl;
			assign den_prev = den;
			for (genvar l = 0; l < LANES; l++) begin : g_lane
				assign rem_prev[l] = num[l][DW+QW-1:QW];
				assign lo_prev[l]  = num[l][QW-1:0];
			end
		end else begin : g_next
			assign ctl_prev = ctl_s[j-1];
			assign den_prev = den_s[j-1];
			assign rem_prev = rem_s[j-1];
			assign lo_prev  = lo_s[j-1];
		end

		// one trial subtraction per lane
		always_comb begin
			logic [DW:0] trial;
			logic [DW:0] diff;
			for (int l = 0; l < LANES; l++) begin
				trial = {rem_prev[l], lo_prev[l][QW-1]};
				diff  = trial - {1'b0, den_prev[l]};
				if (trial >= {1'b0, den_prev[l]}) begin
					rem_next[l] = diff[DW-1:0];
					lo_next[l]  = {lo_prev[l][QW-2:0], 1'b1};
				end else begin
					rem_next[l] = trial[DW-1:0];
					lo_next[l]  = {lo_prev[l][QW-2:0], 1'b0};
				end
			end
		end

		// control travels with the data
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j] <= '0;
			end else begin
				ctl_s[j] <= ctl_prev;
			end
		end

		// payload
		always_ff @(posedge clk) begin
			rem_s[j] <= rem_next;
			den_s[j] <= den_prev;
			lo_s[j]  <= lo_next;
		end
	end

	assign out_ctl = ctl_s[QW-1];
	assign quo     = lo_s[QW-1];

endmodule

FILE: hw/rtl/rgb_to_hsl_converter.sv
// top level of the rgb to hsl converter
//
// one pixel per request: red_level, green_level and blue_level are taken at
// a rising edge with start high and busy low. busy is held low, so a new
// pixel may be sent in every cycle.
// each result (hue_angle in 1/64 degree, saturation_frac and lightness_frac
// as q0.16 fractions) appears on the result ports for one cycle with done
// high. results leave in request order. throughput is one pixel per cycle;
// the divider resolves one quotient bit per stage over 17 stages, behind four
// front stages (input capture, max/min and sector, spread and hue numerator,
// operand setup) and ahead of the output register. lightness is a fixed-ratio
// multiply done during operand setup and rides along with the divider control.
// the receiver cannot hold results off; each result is gone after its cycle.
// reset clears every valid bit at once; requests in flight are dropped and no
// done pulse follows until a new request is taken.
`timescale 1ns / 1ps
`include "rgb_to_hsl_converter_defines.svh"

module rgb_to_hsl_converter
	import rgbhsl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CH_W-1:0]   red_level,
	input  logic [CH_W-1:0]   green_level,
	input  logic [CH_W-1:0]   blue_level,
	output logic              done,
	output logic [HUE_W-1:0]  hue_angle,
	output logic [FRAC_W-1:0] saturation_frac,
	output logic [FRAC_W-1:0] lightness_frac
);

	logic              accept;
	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic [CH_W-1:0]   r_s1, g_s1, b_s1;
	logic [CH_W-1:0]   r_s2, g_s2, b_s2, mx_s2, mn_s2;
	branch_t           br_s2;
	logic [CH_W-1:0]   d_s3;
	logic [CH_W:0]     sum_s3;
	logic [CH_W-1:0]   den_s3;
	logic [10:0]       k_s3;
	logic              gray_s3;
	logic              gray_s4;
	logic [FRAC_W-1:0] lit_s4;
	logic [DIV_LANES-1:0][DIV_NW-1:0] num_s4;
	logic [DIV_LANES-1:0][DIV_DW-1:0] den_s4;

	logic [CH_W-1:0]   mx_c, mn_c;
	branch_t           br_c;
	logic [CH_W-1:0]   d_c;
	logic [CH_W:0]     sum_c;
	logic [CH_W-1:0]   den_c;
	logic [10:0]       k_c;
	logic [DIV_LANES-1:0][DIV_NW-1:0] num_c;
	logic [DIV_LANES-1:0][DIV_DW-1:0] dvs_c;
	logic [FRAC_W-1:0] lit_z_c;
	logic [FRAC_W:0]   lit_t_c;
	logic [CH_W:0]     lit_q_c;
	logic [FRAC_W:0]   lit_full_c;
	logic [FRAC_W-1:0] lit_n_c;

	div_ctl_t          div_in_ctl, div_out_ctl;
	logic [DIV_LANES-1:0][DIV_QW-1:0] quo;
	logic [HUE_W-1:0]  hue_c;
	logic [FRAC_W-1:0] sat_c, lit_c;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// max, min and hue sector
	always_comb begin
		mx_c = r_s1;
		mn_c = r_s1;
		if (g_s1 > mx_c) mx_c = g_s1;
		if (b_s1 > mx_c) mx_c = b_s1;
		if (g_s1 < mn_c) mn_c = g_s1;
		if (b_s1 < mn_c) mn_c = b_s1;
		priority if (r_s1 == mx_c) br_c = BR_RED;
		else if (g_s1 == mx_c)     br_c = BR_GREEN;
		else                       br_c = BR_BLUE;
	end

	// spread, sum, saturation divisor and hue numerator in sixths
	// the 11-bit sums wrap, the true value always lies in 0..6*d
	always_comb begin
		d_c   = mx_s2 - mn_s2;
		sum_c = {1'b0, mx_s2} + {1'b0, mn_s2};
		if (sum_c < 9'(255)) den_c = sum_c[CH_W-1:0];
		else                 den_c = 8'(10'(510) - 10'(sum_c));
		unique case (br_s2)
			BR_RED: begin
				if (g_s2 >= b_s2) k_c = 11'(g_s2) - 11'(b_s2);
				else              k_c = 11'(6) * 11'(d_c) + 11'(g_s2) - 11'(b_s2);
			end
			BR_GREEN: k_c = (11'(d_c) << 1) + 11'(b_s2) - 11'(r_s2);
			BR_BLUE:  k_c = (11'(d_c) << 2) + 11'(r_s2) - 11'(g_s2);
			default:  k_c = '0;
		endcase
	end

	// divider operands, rounding half up as (2n + d) / (2d)
	always_comb begin
		num_c[LANE_HUE] = DIV_NW'(k_s3) * DIV_NW'(2 * HUE_SIXTH) + DIV_NW'(d_s3);
		dvs_c[LANE_HUE] = DIV_DW'(d_s3) << 1;
		num_c[LANE_SAT] = (DIV_NW'(d_s3) << DIV_QW) + DIV_NW'(den_s3);
		dvs_c[LANE_SAT] = DIV_DW'(den_s3) << 1;
	end

	// lightness s/510 rounded: 128s + floor((128s + 127) / 255)
	// the divide by 255 is exact as (z + z/256 + 1) / 256 over this range
	always_comb begin
		lit_z_c    = {sum_s3, 7'd0} + FRAC_W'(127);
		lit_t_c    = {1'b0, lit_z_c} + (FRAC_W+1)'(lit_z_c[FRAC_W-1:CH_W]) + (FRAC_W+1)'(1);
		lit_q_c    = lit_t_c[FRAC_W:CH_W];
		lit_full_c = {1'b0, sum_s3, 7'd0} + (FRAC_W+1)'(lit_q_c);
		lit_n_c    = lit_full_c[FRAC_W] ? '1 : lit_full_c[FRAC_W-1:0];
	end

	// front pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// front pipeline payload
	always_ff @(posedge clk) begin
		r_s1    <= red_level;
		g_s1    <= green_level;
		b_s1    <= blue_level;
		r_s2    <= r_s1;
		g_s2    <= g_s1;
		b_s2    <= b_s1;
		mx_s2   <= mx_c;
		mn_s2   <= mn_c;
		br_s2   <= br_c;
		d_s3    <= d_c;
		sum_s3  <= sum_c;
		den_s3  <= den_c;
		k_s3    <= k_c;
		gray_s3 <= (d_c == '0);
		gray_s4 <= gray_s3;
		lit_s4  <= lit_n_c;
		num_s4  <= num_c;
		den_s4  <= dvs_c;
	end

	assign div_in_ctl.valid = valid_s4;
	assign div_in_ctl.gray  = gray_s4;
	assign div_in_ctl.lit   = lit_s4;

	rgbhsl_divider #(
		.LANES (DIV_LANES),
		.DW    (DIV_DW),
		.QW    (DIV_QW)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (div_in_ctl),
		.num     (num_s4),
		.den     (den_s4),
		.out_ctl (div_out_ctl),
		.quo     (quo)
	);

	// full turn wraps, saturation of one clamps, gray pixels have no hue or saturation
	always_comb begin
		if (div_out_ctl.gray) begin
			hue_c = '0;
			sat_c = '0;
		end else begin
			if (quo[LANE_HUE] >= DIV_QW'(HUE_FULL))
				hue_c = HUE_W'(quo[LANE_HUE] - DIV_QW'(HUE_FULL));
			else
				hue_c = HUE_W'(quo[LANE_HUE]);
			sat_c = quo[LANE_SAT][FRAC_W] ? '1 : quo[LANE_SAT][FRAC_W-1:0];
		end
		lit_c = div_out_ctl.lit;
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_out_ctl.valid;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		hue_angle       <= hue_c;
		saturation_frac <= sat_c;
		lightness_frac  <= lit_c;
	end

	// checks
	`RGBHSL_ASSERT_IMPLY(a_latency, clk, arst_n, done, $past(valid_s1, PIPE_DEPTH), "result strobe without a request")
	`RGBHSL_ASSERT_HOLD(a_never_busy, clk, arst_n, !busy, "busy raised")
	`RGBHSL_ASSERT_IMPLY(a_hue_range, clk, arst_n, done, hue_angle < HUE_W'(HUE_FULL), "hue beyond full turn")
	`RGBHSL_ASSERT_IMPLY(a_gray_hue, clk, arst_n, done && (saturation_frac == '0), hue_angle == '0, "gray pixel with nonzero hue")

endmodule

FILE: tb/rgb_to_hsl_checker.sv
// checker for the rgb to hsl converter: predicts each request and compares its result
`timescale 1ns / 1ps

module rgb_to_hsl_checker
	import rgbhsl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [CH_W-1:0]   red_level,
	input  logic [CH_W-1:0]   green_level,
	input  logic [CH_W-1:0]   blue_level,
	input  logic              done,
	input  logic [HUE_W-1:0]  hue_angle,
	input  logic [FRAC_W-1:0] saturation_frac,
	input  logic [FRAC_W-1:0] lightness_frac,
	output int                fail_count,
	output int                pending_count
);

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [FRAC_W-1:0] sat;
		logic [FRAC_W-1:0] lit;
	} hsl_t;

	localparam longint SIXTH   = HUE_SIXTH;
	localparam longint FULL    = HUE_FULL;
	localparam longint ONE_Q16 = 65536;
	localparam longint MAX_Q16 = 65535;

	hsl_t hsl_queue[$];
	int   mismatches = 0;

	// exact integer hsl of one pixel, each output rounded half up once
	function automatic hsl_t hsl_expected(input logic [CH_W-1:0] r8, input logic [CH_W-1:0] g8,
			input logic [CH_W-1:0] b8);
		longint r, g, b, mx, mn, d, s, den, num, hue, sat, lit;
		hsl_t res;
		r = r8;
		g = g8;
		b = b8;
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		s = mx + mn;
		// lightness is s / 510, a value of one clips
		lit = (2 * s * ONE_Q16 + 510) / 1020;
		if (lit > MAX_Q16) lit = MAX_Q16;
		hue = 0;
		sat = 0;
		// gray pixel keeps zero hue and saturation
		if (d != 0) begin
			den = (s < 255) ? s : 510 - s;
			sat = (2 * d * ONE_Q16 + den) / (2 * den);
			if (sat > MAX_Q16) sat = MAX_Q16;
			// sector select, red wins ties over green, green over blue
			if (r == mx)
				num = (g - b) * SIXTH;
			else if (g == mx)
				num = 2 * SIXTH * d + (b - r) * SIXTH;
			else
				num = 4 * SIXTH * d + (r - g) * SIXTH;
			if (num < 0) num = num + FULL * d;
			hue = (2 * num + d) / (2 * d);
			// full turn wraps to zero
			if (hue >= FULL) hue = hue - FULL;
		end
		res.hue = hue[HUE_W-1:0];
		res.sat = sat[FRAC_W-1:0];
		res.lit = lit[FRAC_W-1:0];
		return res;
	endfunction

	// compare results against the oldest prediction, then predict new requests
	always @(posedge clk or negedge arst_n) begin
		hsl_t want;
		if (!arst_n) begin
			hsl_queue.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (done) begin
				if (hsl_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: hue %0d sat %0d lit %0d",
							hue_angle, saturation_frac, lightness_frac);
				end else begin
					want = hsl_queue.pop_front();
					if (hue_angle !== want.hue || saturation_frac !== want.sat ||
							lightness_frac !== want.lit) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected hue %0d sat %0d lit %0d, got hue %0d sat %0d lit %0d",
								want.hue, want.sat, want.lit,
								hue_angle, saturation_frac, lightness_frac);
					end
				end
			end
			if (start && !busy)
				hsl_queue.push_back(hsl_expected(red_level, green_level, blue_level));
			fail_count <= mismatches;
			pending_count <= hsl_queue.size();
		end
	end

endmodule

FILE: tb/rgb_to_hsl_converter_tb.sv
// testbench top for the rgb to hsl converter: stimulus, timeout and verdict
`timescale 1ns / 1ps

module rgb_to_hsl_converter_tb;
	import rgbhsl_pkg::*;

	localparam int RANDOM_PIXELS = 1330;
	localparam int QUIET_TAIL    = 150;
	localparam int CYCLE_LIMIT   = 200000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CH_W-1:0]   red_level;
	logic [CH_W-1:0]   green_level;
	logic [CH_W-1:0]   blue_level;
	logic              done;
	logic [HUE_W-1:0]  hue_angle;
	logic [FRAC_W-1:0] saturation_frac;
	logic [FRAC_W-1:0] lightness_frac;
	int                fail_count;
	int                pending_count;
	int                cycle_count = 0;

	rgb_to_hsl_converter u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.red_level      (red_level),
		.green_level    (green_level),
		.blue_level     (blue_level),
		.done           (done),
		.hue_angle      (hue_angle),
		.saturation_frac(saturation_frac),
		.lightness_frac (lightness_frac)
	);

	rgb_to_hsl_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.red_level      (red_level),
		.green_level    (green_level),
		.blue_level     (blue_level),
		.done           (done),
		.hue_angle      (hue_angle),
		.saturation_frac(saturation_frac),
		.lightness_frac (lightness_frac),
		.fail_count     (fail_count),
		.pending_count  (pending_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// one pixel request, held until taken; called and returns at a rising edge
	task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b);
		logic taken;
		start <= 1'b1;
		red_level <= r;
		green_level <= g;
		blue_level <= b;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
	endtask

	// idle burst with junk on the pixel lines
	task automatic idle_burst(input int cycles);
		start <= 1'b0;
		red_level <= CH_W'($urandom());
		green_level <= CH_W'($urandom());
		blue_level <= CH_W'($urandom());
		repeat (cycles) @(posedge clk);
	endtask

	// three levels in a random channel order
	task automatic send_shuffled(input int a, input int b, input int c);
		int ch[3];
		int j, t;
		ch[0] = a;
		ch[1] = b;
		ch[2] = c;
		for (int i = 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = ch[i];
			ch[i] = ch[j];
			ch[j] = t;
		end
		send_pixel(CH_W'(ch[0]), CH_W'(ch[1]), CH_W'(ch[2]));
	endtask

	// random pixel drawn from one of several shapes
	task automatic send_random_pixel();
		int kind, hi, lo, mid;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3, 4: begin
				send_pixel(CH_W'($urandom()), CH_W'($urandom()), CH_W'($urandom()));
			end
			5: begin
				// gray
				hi = $urandom_range(0, 255);
				send_pixel(CH_W'(hi), CH_W'(hi), CH_W'(hi));
			end
			6: begin
				// two channels tied at the max
				hi = $urandom_range(1, 255);
				lo = $urandom_range(0, hi - 1);
				send_shuffled(hi, hi, lo);
			end
			7: begin
				// max + min around 255, where the saturation divisor flips
				hi = $urandom_range(128, 255);
				lo = 255 - hi + $urandom_range(0, 4) - 2;
				if (lo < 0) lo = 0;
				if (lo > hi) lo = hi;
				mid = $urandom_range(lo, hi);
				send_shuffled(hi, mid, lo);
			end
			8: begin
				// full-range spread
				send_shuffled(255, $urandom_range(0, 255), 0);
			end
			default: begin
				// small spread
				lo = $urandom_range(0, 252);
				hi = lo + $urandom_range(1, 3);
				mid = $urandom_range(lo, hi);
				send_shuffled(hi, mid, lo);
			end
		endcase
	endtask

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		red_level = '0;
		green_level = '0;
		blue_level = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pixels: extremes, primaries, ties, gray, divisor edge
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd1, 8'd0);
		send_pixel(8'd254, 8'd0, 8'd0);
		send_pixel(8'd128, 8'd127, 8'd127);
		send_pixel(8'd127, 8'd128, 8'd127);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd170, 8'd85, 8'd0);
		send_pixel(8'd0, 8'd85, 8'd170);
		send_pixel(8'd85, 8'd0, 8'd170);
		send_pixel(8'd200, 8'd200, 8'd201);
		idle_burst(3);
		send_pixel(8'd1, 8'd1, 8'd0);

		// random pixels, idle bursts except in the tail
		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			if (n < RANDOM_PIXELS - QUIET_TAIL && $urandom_range(0, 3) == 0)
				idle_burst($urandom_range(1, 13));
			send_random_pixel();
		end
		start <= 1'b0;

		// drain
		do @(negedge clk); while (pending_count != 0);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
